// ===== rtl/skt_pkg.sv =====
package skt_pkg;

	// fixed field widths
	localparam int CMD_W    = 3;
	localparam int STATUS_W = 3;
	localparam int POS_W    = 4;
	localparam int CNT_W    = 5;

	// command codes
	localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_FIND   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_READ   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_POS_EMPTY = 3'd4;

	localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 5'd16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// per-command control broadcast to every cell
	typedef struct packed {
		logic rd_mode;  // match on position instead of key
		logic ins_en;   // apply insert shift this cycle
		logic del_en;   // apply delete shift this cycle
	} cell_ctl_t;

endpackage

// ===== rtl/skt_if.sv =====
// request channel: one table command
interface skt_req_if #(parameter int KW = 32, parameter int VW = 16);
	logic                      valid;
	logic                      ready;
	logic [skt_pkg::CMD_W-1:0] cmd;
	logic [KW-1:0]             key;
	logic [VW-1:0]             value_handle;
	logic [skt_pkg::POS_W-1:0] position;

	modport source (output valid, cmd, key, value_handle, position, input ready);
	modport sink   (input valid, cmd, key, value_handle, position, output ready);
endinterface

// response channel: one result per command
interface skt_rsp_if #(parameter int KW = 32, parameter int VW = 16);
	logic                         valid;
	logic                         ready;
	logic [skt_pkg::STATUS_W-1:0] status;
	logic [KW-1:0]                out_key;
	logic [VW-1:0]                out_value;
	logic [skt_pkg::CNT_W-1:0]    entry_count;

	modport source (output valid, status, out_key, out_value, entry_count, input ready);
	modport sink   (input valid, status, out_key, out_value, entry_count, output ready);
endinterface

// configuration write channel: entry limit
interface skt_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [skt_pkg::CNT_W-1:0] max_entries;

	modport source (output valid, max_entries, input ready);
	modport sink   (input valid, max_entries, output ready);
endinterface

// ===== rtl/sorted_key_table.sv =====
// Sorted key table: a row of DEPTH cells, one entry each, kept in ascending key order.
// The request is registered on accept; the scan state walks the result link down the row.
// Done waits for any earlier response to be taken; a new request is taken only when idle.
// Insert and delete move the entries at and above the affected position together by neighbor shifts.
// Reset (arst_n low, async): table empty, entry limit 16, no response pending.
module sorted_key_table #(
	parameter int DEPTH       = 16,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	skt_req_if.sink    req_ch,
	skt_rsp_if.source  rsp_ch,
	skt_cfg_if.sink    cfg_ch
);

	localparam int SCW = $clog2(DEPTH);

	skt_pkg::state_t                 state_q;
	skt_pkg::state_t                 state_d;
	logic [SCW-1:0]                  scan_q;
	logic [skt_pkg::CNT_W-1:0]       count_q;
	logic [skt_pkg::CNT_W-1:0]       count_d;
	logic [skt_pkg::CNT_W-1:0]       max_entries_q;
	logic [skt_pkg::CNT_W-1:0]       limit;
	logic [skt_pkg::CMD_W-1:0]       cmd_q;
	logic [KEY_WIDTH-1:0]            key_q;
	logic [VALUE_WIDTH-1:0]          val_q;
	logic [skt_pkg::POS_W-1:0]       pos_q;
	logic                            out_valid_q;
	logic [skt_pkg::STATUS_W-1:0]    out_status_q;
	logic [KEY_WIDTH-1:0]            out_key_q;
	logic [VALUE_WIDTH-1:0]          out_value_q;
	logic [skt_pkg::CNT_W-1:0]       out_count_q;
	logic [skt_pkg::STATUS_W-1:0]    status_d;
	logic [KEY_WIDTH-1:0]            okey_d;
	logic [VALUE_WIDTH-1:0]          oval_d;
	logic                            accept;
	logic                            finish;
	logic                            ins_go;
	logic                            del_go;
	skt_pkg::cell_ctl_t              ctl;

	logic [KEY_WIDTH-1:0]            ckey   [DEPTH];
	logic [VALUE_WIDTH-1:0]          cval   [DEPTH];
	logic                            clt    [DEPTH];
	logic                            lfound [DEPTH];
	logic [KEY_WIDTH-1:0]            lkey   [DEPTH];
	logic [VALUE_WIDTH-1:0]          lval   [DEPTH];

	assign accept         = req_ch.valid && req_ch.ready;
	assign req_ch.ready   = (state_q == skt_pkg::ST_IDLE);
	assign cfg_ch.ready   = 1'b1;

	// limit in force: smaller of register and table depth
	assign limit = (32'(max_entries_q) < 32'(DEPTH)) ? max_entries_q
	                                                  : skt_pkg::CNT_W'(DEPTH);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= skt_pkg::MAX_ENTRIES_RST;
		end else if (cfg_ch.valid) begin
			max_entries_q <= cfg_ch.max_entries;
		end
	end

	// held command
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= req_ch.cmd;
			key_q <= req_ch.key;
			val_q <= req_ch.value_handle;
			pos_q <= req_ch.position;
		end
	end

	// result decode from the end of the link chain
	always_comb begin
		status_d = skt_pkg::STATUS_OK;
		okey_d   = '0;
		oval_d   = '0;
		count_d  = count_q;
		ins_go   = 1'b0;
		del_go   = 1'b0;
		unique case (cmd_q)
			skt_pkg::CMD_INSERT: begin
				if (lfound[DEPTH-1]) begin
					status_d = skt_pkg::STATUS_DUPLICATE;
				end else if (count_q >= limit) begin
					status_d = skt_pkg::STATUS_FULL;
				end else begin
					ins_go  = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			skt_pkg::CMD_DELETE: begin
				if (!lfound[DEPTH-1]) begin
					status_d = skt_pkg::STATUS_NOT_FOUND;
				end else begin
					del_go  = 1'b1;
					count_d = count_q - 1'b1;
				end
			end
			skt_pkg::CMD_FIND: begin
				if (!lfound[DEPTH-1]) begin
					status_d = skt_pkg::STATUS_NOT_FOUND;
				end else begin
					oval_d = lval[DEPTH-1];
				end
			end
			skt_pkg::CMD_READ: begin
				if (!lfound[DEPTH-1]) begin
					status_d = skt_pkg::STATUS_POS_EMPTY;
				end else begin
					okey_d = lkey[DEPTH-1];
					oval_d = lval[DEPTH-1];
				end
			end
			skt_pkg::CMD_CLEAR: begin
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	// sequencer: next state and cell controls
	always_comb begin
		state_d     = state_q;
		finish      = 1'b0;
		ctl.rd_mode = (cmd_q == skt_pkg::CMD_READ);
		ctl.ins_en  = 1'b0;
		ctl.del_en  = 1'b0;
		unique case (state_q)
			skt_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = skt_pkg::ST_SCAN;
				end
			end
			skt_pkg::ST_SCAN: begin
				if (scan_q == '0) begin
					state_d = skt_pkg::ST_DONE;
				end
			end
			skt_pkg::ST_DONE: begin
				if (!out_valid_q || rsp_ch.ready) begin
					finish     = 1'b1;
					ctl.ins_en = ins_go;
					ctl.del_en = del_go;
					state_d    = skt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = skt_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= skt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// scan counter: counts down over the cells of the link chain
	always_ff @(posedge clk) begin
		if (accept) begin
			scan_q <= SCW'(DEPTH - 1);
		end else if (state_q == skt_pkg::ST_SCAN) begin
			scan_q <= scan_q - 1'b1;
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (finish) begin
			count_q <= count_d;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_status_q <= status_d;
			out_key_q    <= okey_d;
			out_value_q  <= oval_d;
			out_count_q  <= count_d;
		end
	end

	assign rsp_ch.valid       = out_valid_q;
	assign rsp_ch.status      = out_status_q;
	assign rsp_ch.out_key     = out_key_q;
	assign rsp_ch.out_value   = out_value_q;
	assign rsp_ch.entry_count = out_count_q;

	// row of entry cells
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [KEY_WIDTH-1:0]   pkey;
		logic [VALUE_WIDTH-1:0] pval;
		logic                   plt;
		logic [KEY_WIDTH-1:0]   nkey;
		logic [VALUE_WIDTH-1:0] nval;
		logic                   lin_found;
		logic [KEY_WIDTH-1:0]   lin_key;
		logic [VALUE_WIDTH-1:0] lin_val;

		if (g == 0) begin : g_head
			assign pkey      = ckey[g];
			assign pval      = cval[g];
			assign plt       = 1'b1;
			assign lin_found = 1'b0;
			assign lin_key   = '0;
			assign lin_val   = '0;
		end else begin : g_body
			assign pkey      = ckey[g-1];
			assign pval      = cval[g-1];
			assign plt       = clt[g-1];
			assign lin_found = lfound[g-1];
			assign lin_key   = lkey[g-1];
			assign lin_val   = lval[g-1];
		end

		if (g == DEPTH - 1) begin : g_tail
			assign nkey = ckey[g];
			assign nval = cval[g];
		end else begin : g_mid
			assign nkey = ckey[g+1];
			assign nval = cval[g+1];
		end

		skt_cell #(
			.KW  (KEY_WIDTH),
			.VW  (VALUE_WIDTH),
			.IDX (g)
		) u_cell (
			.clk           (clk),
			.cmd_key       (key_q),
			.cmd_val       (val_q),
			.cmd_pos       (pos_q),
			.count         (count_q),
			.ctl           (ctl),
			.prev_key      (pkey),
			.prev_val      (pval),
			.prev_lt       (plt),
			.next_key      (nkey),
			.next_val      (nval),
			.link_in_found (lin_found),
			.link_in_key   (lin_key),
			.link_in_val   (lin_val),
			.key_o         (ckey[g]),
			.val_o         (cval[g]),
			.lt_o          (clt[g]),
			.link_found_o  (lfound[g]),
			.link_key_o    (lkey[g]),
			.link_val_o    (lval[g])
		);
	end

endmodule

// ===== rtl/skt_cell.sv =====
module skt_cell #(
	parameter int KW  = 32,
	parameter int VW  = 16,
	parameter int IDX = 0
) (
	input  logic                      clk,
	input  logic [KW-1:0]             cmd_key,
	input  logic [VW-1:0]             cmd_val,
	input  logic [skt_pkg::POS_W-1:0] cmd_pos,
	input  logic [skt_pkg::CNT_W-1:0] count,
	input  skt_pkg::cell_ctl_t        ctl,
	input  logic [KW-1:0]             prev_key,
	input  logic [VW-1:0]             prev_val,
	input  logic                      prev_lt,
	input  logic [KW-1:0]             next_key,
	input  logic [VW-1:0]             next_val,
	input  logic                      link_in_found,
	input  logic [KW-1:0]             link_in_key,
	input  logic [VW-1:0]             link_in_val,
	output logic [KW-1:0]             key_o,
	output logic [VW-1:0]             val_o,
	output logic                      lt_o,
	output logic                      link_found_o,
	output logic [KW-1:0]             link_key_o,
	output logic [VW-1:0]             link_val_o
);

	logic [KW-1:0] key_q;
	logic [VW-1:0] val_q;
	logic          link_found_q;
	logic [KW-1:0] link_key_q;
	logic [VW-1:0] link_val_q;
	logic          occ;
	logic          lt;
	logic          hit;

	// local compares against the broadcast command
	assign occ = (32'(IDX) < 32'(count));
	assign lt  = occ && (key_q < cmd_key);
	assign hit = ctl.rd_mode ? (occ && (32'(IDX) == 32'(cmd_pos)))
	                         : (occ && (key_q == cmd_key));

	// result link: first hit along the chain wins
	always_ff @(posedge clk) begin
		if (link_in_found) begin
			link_found_q <= 1'b1;
			link_key_q   <= link_in_key;
			link_val_q   <= link_in_val;
		end else if (hit) begin
			link_found_q <= 1'b1;
			link_key_q   <= key_q;
			link_val_q   <= val_q;
		end else begin
			link_found_q <= 1'b0;
			link_key_q   <= '0;
			link_val_q   <= '0;
		end
	end

	// entry update: insert shifts up, delete shifts down
	always_ff @(posedge clk) begin
		if (ctl.ins_en) begin
			if (!prev_lt) begin
				key_q <= prev_key;
				val_q <= prev_val;
			end else if (!lt) begin
				key_q <= cmd_key;
				val_q <= cmd_val;
			end
		end else if (ctl.del_en) begin
			if (!lt) begin
				key_q <= next_key;
				val_q <= next_val;
			end
		end
	end

	assign key_o        = key_q;
	assign val_o        = val_q;
	assign lt_o         = lt;
	assign link_found_o = link_found_q;
	assign link_key_o   = link_key_q;
	assign link_val_o   = link_val_q;

endmodule

// ===== test/tb_sorted_key_table.sv =====
module tb_sorted_key_table;

	localparam int DEPTH       = 16;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 16;
	localparam int KEY_POOL    = 24;
	localparam int LONG_STALL  = 300;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int MAX_REPORTS = 30;

	// command codes the block must ignore
	localparam logic [skt_pkg::CMD_W-1:0] CMD_BAD_LO = 3'd5;
	localparam logic [skt_pkg::CMD_W-1:0] CMD_BAD_HI = 3'd7;

	typedef struct packed {
		logic [skt_pkg::STATUS_W-1:0] status;
		logic [KEY_W-1:0]             key;
		logic [VAL_W-1:0]             value;
		logic [skt_pkg::CNT_W-1:0]    count;
	} tbl_result_t;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_COIN,
		RX_PATTERN
	} rx_mode_t;

	logic clk;
	logic arst_n;

	skt_req_if #(.KW(KEY_W), .VW(VAL_W)) req_ch ();
	skt_rsp_if #(.KW(KEY_W), .VW(VAL_W)) rsp_ch ();
	skt_cfg_if                           cfg_ch ();

	sorted_key_table #(
		.DEPTH       (DEPTH),
		.KEY_WIDTH   (KEY_W),
		.VALUE_WIDTH (VAL_W)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req_ch (req_ch),
		.rsp_ch (rsp_ch),
		.cfg_ch (cfg_ch)
	);

	// shadow copy of the table
	logic [KEY_W-1:0]          tbl_keys [DEPTH];
	logic [VAL_W-1:0]          tbl_vals [DEPTH];
	int                        tbl_count;
	logic [skt_pkg::CNT_W-1:0] tbl_limit;

	tbl_result_t pending_results[$];
	tbl_result_t head_result;

	logic [KEY_W-1:0] key_pool [KEY_POOL];

	int mismatch_count;
	int cycle_count;
	int burst_left;
	int stall_ask;
	int limit_writes;
	int ignored_seen;
	int cmd_seen    [8];
	int status_seen [8];

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("cycle %0d: %s", cycle_count, msg);
		end
	endtask

	// index of key k in the shadow table, -1 when absent
	function automatic int table_locate(input logic [KEY_W-1:0] k);
		for (int i = 0; i < tbl_count; i++) begin
			if (tbl_keys[i] == k) return i;
		end
		return -1;
	endfunction

	// runs one command on the shadow table and returns the response it must give
	function automatic tbl_result_t table_apply(input logic [skt_pkg::CMD_W-1:0] op,
			input logic [KEY_W-1:0] k, input logic [VAL_W-1:0] v,
			input logic [skt_pkg::POS_W-1:0] p);
		tbl_result_t r;
		int          hit;
		int          at;
		int          lim;
		r   = '0;
		hit = table_locate(k);
		lim = (tbl_limit < DEPTH) ? int'(tbl_limit) : DEPTH;
		case (op)
			skt_pkg::CMD_INSERT: begin
				if (hit >= 0) begin
					r.status = skt_pkg::STATUS_DUPLICATE;
				end else if (tbl_count >= lim) begin
					r.status = skt_pkg::STATUS_FULL;
				end else begin
					at = 0;
					while (at < tbl_count && tbl_keys[at] < k) at++;
					for (int i = tbl_count; i > at; i--) begin
						tbl_keys[i] = tbl_keys[i-1];
						tbl_vals[i] = tbl_vals[i-1];
					end
					tbl_keys[at] = k;
					tbl_vals[at] = v;
					tbl_count++;
				end
			end
			skt_pkg::CMD_DELETE: begin
				if (hit < 0) begin
					r.status = skt_pkg::STATUS_NOT_FOUND;
				end else begin
					for (int i = hit; i + 1 < tbl_count; i++) begin
						tbl_keys[i] = tbl_keys[i+1];
						tbl_vals[i] = tbl_vals[i+1];
					end
					tbl_count--;
				end
			end
			skt_pkg::CMD_FIND: begin
				if (hit < 0) r.status = skt_pkg::STATUS_NOT_FOUND;
				else r.value = tbl_vals[hit];
			end
			skt_pkg::CMD_READ: begin
				if (int'(p) >= tbl_count) begin
					r.status = skt_pkg::STATUS_POS_EMPTY;
				end else begin
					r.key   = tbl_keys[p];
					r.value = tbl_vals[p];
				end
			end
			skt_pkg::CMD_CLEAR: tbl_count = 0;
			default: ;
		endcase
		r.count = tbl_count[skt_pkg::CNT_W-1:0];
		return r;
	endfunction

	// offer one request, predict on accept, then maybe end the burst
	task automatic send_req(input logic [skt_pkg::CMD_W-1:0] op, input logic [KEY_W-1:0] k,
			input logic [VAL_W-1:0] v, input logic [skt_pkg::POS_W-1:0] p);
		req_ch.valid        <= 1'b1;
		req_ch.cmd          <= op;
		req_ch.key          <= k;
		req_ch.value_handle <= v;
		req_ch.position     <= p;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(table_apply(op, k, v, p));
		cmd_seen[op]++;
		burst_left--;
		if (burst_left <= 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 25)) @(posedge clk);
			// now and then a long burst with no gaps at all
			if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(40, 80);
			else burst_left = $urandom_range(1, 12);
		end
	endtask

	// stop offering and wait until every response has come back
	task automatic wait_drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_limit(input logic [skt_pkg::CNT_W-1:0] lim);
		wait_drain();
		repeat (DEPTH + 3) @(posedge clk);
		cfg_ch.valid       <= 1'b1;
		cfg_ch.max_entries <= lim;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		tbl_limit = lim;
		limit_writes++;
	endtask

	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(0, 9) < 8) return key_pool[$urandom_range(0, KEY_POOL - 1)];
		return KEY_W'($urandom);
	endfunction

	function automatic logic [skt_pkg::POS_W-1:0] pick_pos();
		int top;
		top = (tbl_count > DEPTH - 1) ? DEPTH - 1 : tbl_count;
		if ($urandom_range(0, 9) < 7) return skt_pkg::POS_W'($urandom_range(0, top));
		return skt_pkg::POS_W'($urandom_range(0, DEPTH - 1));
	endfunction

	// inserts are the most common command so the table fills; clears are rare
	function automatic logic [skt_pkg::CMD_W-1:0] pick_cmd();
		int r;
		r = $urandom_range(0, 99);
		if (r < 38) return skt_pkg::CMD_INSERT;
		if (r < 58) return skt_pkg::CMD_DELETE;
		if (r < 76) return skt_pkg::CMD_FIND;
		if (r < 94) return skt_pkg::CMD_READ;
		if (r < 97) return skt_pkg::CMD_CLEAR;
		return skt_pkg::CMD_W'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
	endfunction

	task automatic send_random();
		send_req(pick_cmd(), pick_key(), VAL_W'($urandom), pick_pos());
	endtask

	task automatic refill_key_pool();
		for (int i = 0; i < KEY_POOL; i++) key_pool[i] = KEY_W'($urandom);
		key_pool[0] = '0;
		key_pool[1] = '1;
	endtask

	// each command at least once, plus the key extremes, misses and ignored codes
	task automatic test_directed_basics();
		int c;
		send_req(skt_pkg::CMD_INSERT, 32'h8000_0000, 16'hffff, 4'd0);
		send_req(skt_pkg::CMD_INSERT, 32'h0000_0000, 16'h0000, 4'd0);
		send_req(skt_pkg::CMD_INSERT, 32'hffff_ffff, 16'h5a5a, 4'd0);
		send_req(skt_pkg::CMD_INSERT, 32'h0000_0000, 16'h1111, 4'd0);
		send_req(skt_pkg::CMD_FIND,   32'hffff_ffff, 16'h0000, 4'd0);
		send_req(skt_pkg::CMD_FIND,   32'h0000_0005, 16'h0000, 4'd0);
		send_req(skt_pkg::CMD_READ,   32'h0000_0000, 16'h0000, 4'd0);
		send_req(skt_pkg::CMD_READ,   32'h0000_0000, 16'h0000, 4'd2);
		send_req(skt_pkg::CMD_READ,   32'h0000_0000, 16'h0000, 4'd3);
		send_req(skt_pkg::CMD_READ,   32'h0000_0000, 16'h0000, 4'd15);
		send_req(skt_pkg::CMD_DELETE, 32'h8000_0000, 16'h0000, 4'd0);
		send_req(skt_pkg::CMD_DELETE, 32'h8000_0000, 16'h0000, 4'd0);
		for (c = CMD_BAD_LO; c <= CMD_BAD_HI; c++) begin
			send_req(c[skt_pkg::CMD_W-1:0], KEY_W'($urandom), VAL_W'($urandom),
				skt_pkg::POS_W'($urandom_range(0, DEPTH - 1)));
		end
		send_req(skt_pkg::CMD_CLEAR,  32'h0000_0000, 16'h0000, 4'd0);
		send_req(skt_pkg::CMD_READ,   32'h0000_0000, 16'h0000, 4'd0);
		send_req(skt_pkg::CMD_FIND,   32'h0000_0000, 16'h0000, 4'd0);
		send_req(skt_pkg::CMD_DELETE, 32'h0000_0000, 16'h0000, 4'd0);
	endtask

	// full limit, duplicate checked ahead of full, zero limit, limit under the count
	task automatic test_limit_edges();
		write_limit(5'd2);
		send_req(skt_pkg::CMD_INSERT, 32'd10, 16'h0a0a, 4'd0);
		send_req(skt_pkg::CMD_INSERT, 32'd20, 16'h1414, 4'd0);
		send_req(skt_pkg::CMD_INSERT, 32'd30, 16'h1e1e, 4'd0);
		send_req(skt_pkg::CMD_INSERT, 32'd10, 16'h0b0b, 4'd0);
		write_limit(5'd0);
		send_req(skt_pkg::CMD_INSERT, 32'd40, 16'h2828, 4'd0);
		send_req(skt_pkg::CMD_READ,   32'd0,  16'h0000, 4'd1);
		write_limit(5'd1);
		send_req(skt_pkg::CMD_DELETE, 32'd20, 16'h0000, 4'd0);
		send_req(skt_pkg::CMD_INSERT, 32'd50, 16'h3232, 4'd0);
		send_req(skt_pkg::CMD_DELETE, 32'd10, 16'h0000, 4'd0);
		send_req(skt_pkg::CMD_INSERT, 32'd60, 16'h3c3c, 4'd0);
		send_req(skt_pkg::CMD_CLEAR,  32'd0,  16'h0000, 4'd0);
	endtask

	// random traffic over a series of limits; moving down with a full table
	// also lowers the limit below the held count
	task automatic test_random_phases();
		logic [skt_pkg::CNT_W-1:0] limits [9];
		int                        n;
		limits = '{5'd16, 5'd31, 5'd0, 5'd3, 5'd1, 5'd16, 5'd9, 5'd15, 5'd0};
		limits[8] = skt_pkg::CNT_W'($urandom_range(2, 31));
		foreach (limits[ph]) begin
			write_limit(limits[ph]);
			refill_key_pool();
			n = (limits[ph] == 0) ? 40 : 120;
			for (int i = 0; i < n; i++) begin
				send_random();
				if ($urandom_range(0, 59) == 0) wait_drain();
			end
		end
	endtask

	// receiver holds off while requests keep coming, then a full drain and more traffic
	task automatic test_backpressure();
		write_limit(5'd16);
		stall_ask++;
		for (int i = 0; i < 40; i++) send_random();
		wait_drain();
		for (int i = 0; i < 20; i++) send_random();
	endtask

	// response ready: long hold-off on request, otherwise a changing pattern
	initial begin
		int       hold_left;
		int       stall_seen;
		int       mode_left;
		rx_mode_t mode;
		logic [7:0] pattern;
		hold_left  = 0;
		stall_seen = 0;
		mode_left  = 0;
		mode       = RX_FREE;
		pattern    = 8'hff;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_ask != stall_seen) begin
				stall_seen = stall_ask;
				hold_left  = LONG_STALL;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(20, 150);
					pattern   = 8'($urandom);
				end else begin
					mode_left--;
				end
				case (mode)
					RX_FREE:    rsp_ch.ready <= 1'b1;
					RX_COIN:    rsp_ch.ready <= 1'($urandom_range(0, 1));
					default: begin
						rsp_ch.ready <= pattern[0];
						pattern = {pattern[0], pattern[7:1]};
					end
				endcase
			end
		end
	end

	// response check against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			status_seen[rsp_ch.status]++;
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("response with nothing outstanding, status %0d",
					rsp_ch.status));
			end else begin
				head_result = pending_results.pop_front();
				if (rsp_ch.status !== head_result.status)
					report_mismatch($sformatf("status %0d, expected %0d",
						rsp_ch.status, head_result.status));
				if (rsp_ch.out_key !== head_result.key)
					report_mismatch($sformatf("out_key 0x%0h, expected 0x%0h",
						rsp_ch.out_key, head_result.key));
				if (rsp_ch.out_value !== head_result.value)
					report_mismatch($sformatf("out_value 0x%0h, expected 0x%0h",
						rsp_ch.out_value, head_result.value));
				if (rsp_ch.entry_count !== head_result.count)
					report_mismatch($sformatf("entry_count %0d, expected %0d",
						rsp_ch.entry_count, head_result.count));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding",
				cycle_count, pending_results.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		arst_n              <= 1'b0;
		req_ch.valid        <= 1'b0;
		req_ch.cmd          <= skt_pkg::CMD_INSERT;
		req_ch.key          <= '0;
		req_ch.value_handle <= '0;
		req_ch.position     <= '0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.max_entries  <= '0;
		mismatch_count = 0;
		cycle_count    = 0;
		stall_ask      = 0;
		limit_writes   = 0;
		ignored_seen   = 0;
		burst_left     = $urandom_range(1, 12);
		foreach (cmd_seen[i]) cmd_seen[i] = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
		tbl_count = 0;
		tbl_limit = skt_pkg::MAX_ENTRIES_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_basics();
		test_limit_edges();
		test_random_phases();
		test_backpressure();

		wait_drain();
		repeat (DEPTH + 3) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch($sformatf("%0d responses never arrived", pending_results.size()));

		for (int c = CMD_BAD_LO; c <= CMD_BAD_HI; c++) ignored_seen += cmd_seen[c];
		$display("requests: insert %0d, delete %0d, find %0d, read %0d, clear %0d, ignored %0d",
			cmd_seen[skt_pkg::CMD_INSERT], cmd_seen[skt_pkg::CMD_DELETE],
			cmd_seen[skt_pkg::CMD_FIND], cmd_seen[skt_pkg::CMD_READ],
			cmd_seen[skt_pkg::CMD_CLEAR], ignored_seen);
		$display("responses: ok %0d, duplicate %0d, full %0d, missing %0d, empty slot %0d",
			status_seen[skt_pkg::STATUS_OK], status_seen[skt_pkg::STATUS_DUPLICATE],
			status_seen[skt_pkg::STATUS_FULL], status_seen[skt_pkg::STATUS_NOT_FOUND],
			status_seen[skt_pkg::STATUS_POS_EMPTY]);
		$display("%0d limit writes", limit_writes);
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/skt_pkg.sv
rtl/skt_if.sv
rtl/skt_cell.sv
rtl/sorted_key_table.sv
test/tb_sorted_key_table.sv
